>>> design/md5_pkg.sv
// Package with the types, constants and tables of the MD5 digest core.
`default_nettype none
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       msg_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        digest_last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Start and result signals between the sequencer and the round unit.
    typedef struct packed {
        logic start;
    } t_rnd_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rnd_sts;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // Additive constant of each round.
    function automatic logic [31:0] sine_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    // Left rotate amount of each round.
    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // Message word used in each round.
    function automatic logic [3:0] word_sel(input logic [5:0] r);
        logic [3:0] g;
        begin
            unique case (r[5:4])
                2'd0:    g = r[3:0];
                2'd1:    g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
                2'd2:    g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
                default: g = 4'((r[3:0] << 3) - r[3:0]);
            endcase
            return g;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/md5_round_unit.sv
// Shared MD5 round unit: one round per cycle over a block held in a small memory.
`default_nettype none
module md5_round_unit
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_rnd_ctl    i_ctl,
    input  wire logic        i_wr_en,
    input  wire logic [3:0]  i_wr_addr,
    input  wire logic [31:0] i_wr_data,
    input  wire logic [31:0] i_cv_a,
    input  wire logic [31:0] i_cv_b,
    input  wire logic [31:0] i_cv_c,
    input  wire logic [31:0] i_cv_d,
    output t_rnd_sts         o_sts,
    output logic [31:0]      o_wa,
    output logic [31:0]      o_wb,
    output logic [31:0]      o_wc,
    output logic [31:0]      o_wd
);

    logic [31:0] r_mem [16];
    logic [31:0] r_mword;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_round;
    logic        r_busy;
    logic        r_done;
    logic [31:0] n_f;
    logic [31:0] n_sum;
    logic [31:0] n_rot;
    logic [4:0]  n_sh;

    // Block word store, written by the byte packer and the padding sequencer.
    // The word for the coming round is read ahead into a register.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.start && !r_busy) begin
            r_mword <= r_mem[word_sel(6'd0)];
        end else if (r_busy) begin
            r_mword <= r_mem[word_sel(r_round + 6'd1)];
        end
    end

    // Round function, addition chain and rotate.
    always_comb begin
        unique case (r_round[5:4])
            2'd0:    n_f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    n_f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    n_f = r_b ^ r_c ^ r_d;
            default: n_f = r_c ^ (r_b | ~r_d);
        endcase
        n_sum = n_f + r_a + sine_const(r_round) + r_mword;
        n_sh  = rot_amount(r_round);
        n_rot = (n_sum << n_sh) | (n_sum >> (6'd32 - {1'b0, n_sh}));
    end

    // Working registers and round counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                r_a <= i_cv_a; r_b <= i_cv_b; r_c <= i_cv_c; r_d <= i_cv_d;
            end else if (r_busy) begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + n_rot;
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_wa = r_a;
    assign o_wb = r_b;
    assign o_wc = r_c;
    assign o_wd = r_d;

    // The round counter is back at zero when a compression has finished.
    a_done_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_round == 6'd0) else $error("round counter not wrapped");
    // A finished compression follows the last busy round.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    // Idle unit keeps its counter at zero.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_round == 6'd0) else $error("counter moves while idle");

endmodule
`default_nettype wire

>>> design/md5_message_digest_core.sv
// MD5 digest core top level: byte packer, padding sequencer and digest output.
//
// Input channel: one transaction carries one optional message byte and an
// end-of-message flag. Bytes are packed little-endian into a 16-word block.
// A byte without the end flag that does not fill a block is taken without a
// stall. The 64th byte of a block starts a compression, one round per cycle
// through the shared round unit; the round unit then flags the end, the
// sequencer folds the result into the chaining values, and input stalls
// until the fold is done.
// At message end the sequencer writes the pad byte and zero fill one byte a
// cycle and the bit length one word a cycle,
// compresses once or twice, then offers four output transactions, words A,
// B, C and D, the last one marked. The output register holds while the
// receiver stalls, and the input stays stalled until word D is taken.
// Reset (synchronous, active low) loads the initial chaining values, clears
// the byte count and leaves the block store unwritten.
`default_nettype none
module md5_message_digest_core
    import md5_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_data
);

    t_state      r_state, n_state;
    logic [31:0] r_cv [4];
    logic [63:0] r_count;
    logic [5:0]  r_pos;
    logic [31:0] r_word;
    logic        r_fin;
    logic        r_last_blk;
    logic        r_end;
    logic [1:0]  r_oidx;
    logic        r_ovalid;
    logic        r_fold;
    t_rnd_ctl    n_ctl;
    t_rnd_sts    w_sts;
    logic        n_wr_en;
    logic [3:0]  n_wr_addr;
    logic [31:0] n_wr_data;
    logic [31:0] w_wa, w_wb, w_wc, w_wd;
    logic [31:0] n_word;
    logic        w_acc;
    logic [63:0] w_bits;

    md5_round_unit u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (n_ctl),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (n_wr_addr),
        .i_wr_data (n_wr_data),
        .i_cv_a    (r_cv[0]),
        .i_cv_b    (r_cv[1]),
        .i_cv_c    (r_cv[2]),
        .i_cv_d    (r_cv[3]),
        .o_sts     (w_sts),
        .o_wa      (w_wa),
        .o_wb      (w_wb),
        .o_wc      (w_wc),
        .o_wd      (w_wd)
    );

    assign w_acc  = i_valid && !o_stall;
    assign w_bits = {r_count[60:0], 3'b000};

    // Next state, byte packing and block store writes.
    always_comb begin
        n_state   = r_state;
        n_ctl     = '0;
        n_wr_en   = 1'b0;
        n_wr_addr = r_pos[5:2];
        n_word    = r_word;
        n_wr_data = r_word;
        o_stall   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (w_acc && i_data.byte_valid) begin
                    unique case (r_pos[1:0])
                        2'd0:    n_word = {24'd0, i_data.data_byte};
                        2'd1:    n_word = {16'd0, i_data.data_byte, r_word[7:0]};
                        2'd2:    n_word = {8'd0, i_data.data_byte, r_word[15:0]};
                        default: n_word = {i_data.data_byte, r_word[23:0]};
                    endcase
                    n_wr_en   = 1'b1;
                    n_wr_data = n_word;
                    if (r_pos == 6'd63) begin
                        n_ctl.start = 1'b1;
                        n_state = ST_ROUND;
                    end else if (i_data.msg_end) begin
                        n_state = ST_PAD;
                    end
                end else if (w_acc && i_data.msg_end) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                // One pad byte or one length word per cycle.
                n_wr_en = 1'b1;
                if (r_last_blk && r_pos[5:2] == 4'd14) begin
                    n_wr_data = w_bits[31:0];
                end else if (r_last_blk && r_pos[5:2] == 4'd15) begin
                    n_wr_data = w_bits[63:32];
                    n_ctl.start = 1'b1;
                    n_state = ST_ROUND;
                end else begin
                    unique case (r_pos[1:0])
                        2'd0:    n_word = {24'd0, r_fin ? 8'd0 : PAD_BYTE};
                        2'd1:    n_word = {16'd0, r_fin ? 8'd0 : PAD_BYTE, r_word[7:0]};
                        2'd2:    n_word = {8'd0, r_fin ? 8'd0 : PAD_BYTE, r_word[15:0]};
                        default: n_word = {r_fin ? 8'd0 : PAD_BYTE, r_word[23:0]};
                    endcase
                    n_wr_data = n_word;
                    if (r_pos == 6'd63) begin
                        n_ctl.start = 1'b1;
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                // After the fold: more input, another pad block, or the digest.
                if (r_fold) begin
                    if (!r_end) begin
                        n_state = ST_IDLE;
                    end else if (r_fin && r_last_blk) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_EMIT: begin
                if (r_ovalid && !i_stall && r_oidx == 2'd3) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer registers, chaining values and byte count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_pos      <= '0;
            r_fin      <= 1'b0;
            r_last_blk <= 1'b0;
            r_end      <= 1'b0;
            r_fold     <= 1'b0;
            r_oidx     <= '0;
            r_ovalid   <= 1'b0;
            r_cv[0] <= IV_A; r_cv[1] <= IV_B; r_cv[2] <= IV_C; r_cv[3] <= IV_D;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_fold  <= w_sts.done;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc && i_data.byte_valid) begin
                        r_count <= r_count + 64'd1;
                        r_pos   <= r_pos + 6'd1;
                    end
                    if (w_acc && i_data.msg_end) begin
                        // The pad block also carries the length when it fits.
                        r_fin <= 1'b0;
                        r_end <= 1'b1;
                        if (i_data.byte_valid) begin
                            r_last_blk <= (r_pos < 6'd55);
                        end else begin
                            r_last_blk <= (r_pos < 6'd56);
                        end
                    end
                end
                ST_PAD: begin
                    if (r_pos[1:0] == 2'd0 && r_last_blk && r_pos[5:2] >= 4'd14) begin
                        r_pos <= r_pos + 6'd4;
                    end else begin
                        r_pos <= r_pos + 6'd1;
                    end
                    r_fin <= 1'b1;
                end
                ST_ROUND: begin
                    if (r_fold) begin
                        r_cv[0] <= r_cv[0] + w_wa;
                        r_cv[1] <= r_cv[1] + w_wb;
                        r_cv[2] <= r_cv[2] + w_wc;
                        r_cv[3] <= r_cv[3] + w_wd;
                        if (r_end && r_fin && r_last_blk) begin
                            r_ovalid <= 1'b1;
                            r_oidx   <= '0;
                        end else if (r_end) begin
                            // The next pad block is the one with the length.
                            r_last_blk <= 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (r_ovalid && !i_stall) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            r_ovalid <= 1'b0;
                            r_count  <= '0;
                            r_pos    <= '0;
                            r_fin    <= 1'b0;
                            r_end    <= 1'b0;
                            r_last_blk <= 1'b0;
                            r_cv[0] <= IV_A; r_cv[1] <= IV_B;
                            r_cv[2] <= IV_C; r_cv[3] <= IV_D;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid            = r_ovalid;
    assign o_data.digest_word = r_cv[r_oidx];
    assign o_data.word_index  = r_oidx;
    assign o_data.digest_last = (r_oidx == 2'd3);

    // Output transactions only appear while the digest is being shown.
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == ST_EMIT) else $error("output outside emit");
    // Input is never accepted while a compression runs.
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.busy |-> o_stall) else $error("input taken while busy");
    // A stalled digest word keeps its index.
    a_hold_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> $stable(r_oidx)) else $error("index moved");
    // After word D is taken the chaining values are back at their initial value.
    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_stall && r_oidx == 2'd3) |=> r_cv[0] == IV_A)
        else $error("chain not reinitialized");

endmodule
`default_nettype wire
